// ===== design/nfmt_pkg.sv =====
// ----------------------------------------------------------------------------
// nfmt_pkg
// Shared types and constants for the number-to-ASCII formatter.
// ----------------------------------------------------------------------------
package nfmt_pkg;

  // value and digit geometry
  localparam int VAL_W   = 32;
  localparam int NDIG    = 10;            // decimal digits of a 32-bit value
  localparam int POS_W   = 4;             // indexes NDIG digits
  localparam int DD_BITS = 4;             // double-dabble bits per cycle
  localparam int DD_CYC  = VAL_W / DD_BITS;
  localparam int CNT_W   = 3;             // counts double-dabble steps

  // request queue geometry
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = 1;
  localparam int QCNT_W  = 2;

  // output formats, coded as the opcode
  typedef enum logic [2:0] {
    FMT_DEC4 = 3'd0,
    FMT_DECU = 3'd1,
    FMT_DECS = 3'd2,
    FMT_HEX2 = 3'd3,
    FMT_HEX4 = 3'd4
  } fmt_t;

  typedef logic [NDIG-1:0][3:0] digits_t;

  // classified request passed from front to back
  typedef struct packed {
    fmt_t             fmt;
    logic             neg;
    logic [VAL_W-1:0] num;
  } job_t;

  // queue control between front, queue and back
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_CONV,
    BK_SETUP,
    BK_EMIT
  } bk_state_t;

  // characters
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_MINUS = 8'h2d;

  // digit set, index 0 is '0'
  localparam logic [15:0][7:0] HEX_DIGITS = "fedcba9876543210";

endpackage

// ===== design/nfmt_front.sv =====
// ----------------------------------------------------------------------------
// nfmt_front
// Accepts requests, drops unknown opcodes and prepares the number to convert.
// ----------------------------------------------------------------------------
module nfmt_front
  import nfmt_pkg::*;
(
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [2:0]       in_opcode,
  input  logic [VAL_W-1:0] in_value,
  input  q_status_t        q_status,
  output logic             push,
  output job_t             push_data
);

  logic        legal;
  logic [15:0] neg16;

  assign neg16 = 16'(~in_value[15:0] + 16'd1);

  // classify opcode and form the magnitude
  always_comb begin
    legal          = 1'b1;
    push_data.fmt  = FMT_DEC4;
    push_data.neg  = 1'b0;
    push_data.num  = {16'b0, in_value[15:0]};
    case (in_opcode)
      FMT_DEC4: begin
        push_data.fmt = FMT_DEC4;
      end
      FMT_DECU: begin
        push_data.fmt = FMT_DECU;
        push_data.num = in_value;
      end
      FMT_DECS: begin
        push_data.fmt = FMT_DECS;
        push_data.neg = in_value[15];
        if (in_value[15]) begin
          push_data.num = {16'b0, neg16};
        end
      end
      FMT_HEX2: begin
        push_data.fmt = FMT_HEX2;
      end
      FMT_HEX4: begin
        push_data.fmt = FMT_HEX4;
      end
      default: begin
        legal = 1'b0;
      end
    endcase
  end

  // stall only on a full queue; unknown opcodes are taken and dropped
  assign in_stall = q_status.full;
  assign push     = in_valid && !q_status.full && legal;

endmodule

// ===== design/nfmt_fifo.sv =====
// ----------------------------------------------------------------------------
// nfmt_fifo
// Short request queue between the front and the back.
// ----------------------------------------------------------------------------
module nfmt_fifo
  import nfmt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  job_t      push_data,
  input  logic      pop,
  output job_t      pop_data,
  output q_status_t q_status
);

  job_t              q_mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign q_status.full  = (cnt_r == QCNT_W'(QDEPTH));
  assign q_status.empty = (cnt_r == '0);
  assign pop_data       = q_mem[rd_ptr_r];

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = push ? QPTR_W'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? QPTR_W'(rd_ptr_r + 1'b1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = QCNT_W'(cnt_r + 1'b1);
    end else if (pop && !push) begin
      cnt_nxt = QCNT_W'(cnt_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= push_data;
    end
  end

  // no write into a full queue, no read from an empty one
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_status.full |-> !push)
    else $error("request queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_status.empty |-> !pop)
    else $error("request queue underflow");

endmodule

// ===== design/nfmt_back.sv =====
// ----------------------------------------------------------------------------
// nfmt_back
// Converts a queued request to digits and emits its characters.
// ----------------------------------------------------------------------------
module nfmt_back
  import nfmt_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  q_status_t  q_status,
  input  job_t       pop_data,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_character,
  output logic       out_last
);

  bk_state_t        state_r, state_nxt;
  fmt_t             fmt_r;
  logic             sign_r;
  logic [VAL_W-1:0] sh_r;
  digits_t          bcd_r;
  logic [CNT_W-1:0] cnt_r;
  logic [POS_W-1:0] pos_r;
  logic [POS_W-1:0] msd_r;
  logic             out_valid_r;
  logic [7:0]       out_char_r;
  logic             out_last_r;

  logic             out_free;
  logic             emit;
  logic             is_hex;
  digits_t          dd_bcd;
  logic [VAL_W-1:0] dd_sh;
  logic [POS_W-1:0] msd;
  logic [POS_W-1:0] start;
  logic [7:0]       ch;
  logic             ch_last;

  assign out_free = !out_valid_r || !out_stall;
  assign is_hex   = (pop_data.fmt == FMT_HEX2) || (pop_data.fmt == FMT_HEX4);

  // double dabble, DD_BITS bits per cycle
  always_comb begin
    logic [NDIG*4:0]  tv;
    digits_t          t;
    logic [VAL_W-1:0] s;
    t  = bcd_r;
    s  = sh_r;
    tv = '0;
    for (int b = 0; b < DD_BITS; b++) begin
      for (int d = 0; d < NDIG; d++) begin
        if (t[d] >= 4'd5) begin
          t[d] = 4'(t[d] + 4'd3);
        end
      end
      tv = {t, s[VAL_W-1]};
      t  = tv[NDIG*4-1:0];
      s  = {s[VAL_W-2:0], 1'b0};
    end
    dd_bcd = t;
    dd_sh  = s;
  end

  // highest nonzero digit; dec4 looks at its four digits only
  always_comb begin
    msd = '0;
    for (int i = 0; i < NDIG; i++) begin
      if (bcd_r[i] != 4'd0 && (fmt_r != FMT_DEC4 || i < 4)) begin
        msd = POS_W'(i);
      end
    end
  end

  // first digit position to print
  always_comb begin
    case (fmt_r)
      FMT_DEC4: start = POS_W'(3);
      FMT_DECU: start = msd;
      FMT_DECS: start = msd;
      FMT_HEX2: start = POS_W'(1);
      FMT_HEX4: start = POS_W'(3);
      default:  start = '0;
    endcase
  end

  // character at the current position
  always_comb begin
    ch_last = 1'b0;
    if (sign_r) begin
      ch = CH_MINUS;
    end else if (fmt_r == FMT_DEC4 && pos_r > msd_r) begin
      ch = CH_SPACE;
    end else begin
      ch = HEX_DIGITS[bcd_r[pos_r]];
    end
    if (!sign_r && pos_r == '0) begin
      ch_last = 1'b1;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (!q_status.empty) begin
          state_nxt = is_hex ? BK_SETUP : BK_CONV;
        end
      end
      BK_CONV: begin
        if (cnt_r == CNT_W'(DD_CYC - 1)) begin
          state_nxt = BK_SETUP;
        end
      end
      BK_SETUP: begin
        state_nxt = BK_EMIT;
      end
      BK_EMIT: begin
        if (out_free && ch_last) begin
          state_nxt = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  // state outputs
  always_comb begin
    pop  = 1'b0;
    emit = 1'b0;
    case (state_r)
      BK_IDLE:  pop  = !q_status.empty;
      BK_EMIT:  emit = out_free;
      default: begin
        pop  = 1'b0;
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // conversion datapath
  always_ff @(posedge clk) begin
    if (pop) begin
      fmt_r  <= pop_data.fmt;
      sign_r <= pop_data.neg;
      sh_r   <= pop_data.num;
      cnt_r  <= '0;
      if (is_hex) begin
        bcd_r <= digits_t'({{(NDIG*4-16){1'b0}}, pop_data.num[15:0]});
      end else begin
        bcd_r <= '0;
      end
    end else if (state_r == BK_CONV) begin
      bcd_r <= dd_bcd;
      sh_r  <= dd_sh;
      cnt_r <= CNT_W'(cnt_r + 1'b1);
    end else if (state_r == BK_SETUP) begin
      pos_r <= start;
      msd_r <= msd;
    end else if (emit) begin
      if (sign_r) begin
        sign_r <= 1'b0;
      end else begin
        pos_r <= POS_W'(pos_r - 1'b1);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_char_r <= ch;
      out_last_r <= ch_last;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_character = out_char_r;
  assign out_last      = out_last_r;

  // a minus sign is never the final character
  a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) && $past(sign_r) |-> !out_last_r)
    else $error("sign emitted as last character");

  // digit position stays inside the digit register while emitting
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == BK_EMIT |-> pos_r <= POS_W'(NDIG - 1))
    else $error("digit position out of range");

  // leaving emit always follows a last character
  a_done_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == BK_EMIT && state_nxt == BK_IDLE |=> out_valid_r && out_last_r)
    else $error("request finished without last character");

endmodule

// ===== design/number_to_ascii_formatter_top.sv =====
// ----------------------------------------------------------------------------
// number_to_ascii_formatter_top
// Formats binary values as ASCII decimal or hex text, one character a beat.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall): one request carries in_opcode and
// in_value. Opcodes 0..4 select dec4 padded, unsigned dec, signed dec,
// hex8 and hex16; other opcodes are accepted and produce no output.
// Output channel (out_valid / out_stall): one character per beat, most
// significant first, out_last high on the final character of a number.
// A two-entry request queue sits between intake and conversion, so intake
// continues while a number is being printed, until the queue fills.
// Decimal requests run double dabble (4 bits per cycle) and then a
// set-up state before the first character; hex requests go straight to
// the set-up state. Characters of a number then follow one per cycle
// while the output is not stalled.
// A stall on the output holds the character register; emission of the
// current number waits and new requests queue up. Reset (rst_n low,
// synchronous) empties the queue, drops any pending characters and
// clears out_valid.
// ----------------------------------------------------------------------------
module number_to_ascii_formatter_top
  import nfmt_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [2:0]       in_opcode,
  input  logic [VAL_W-1:0] in_value,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       out_character,
  output logic             out_last
);

  q_status_t q_status;
  logic      push;
  job_t      push_data;
  logic      pop;
  job_t      pop_data;

  nfmt_front u_front (
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_opcode (in_opcode),
    .in_value  (in_value),
    .q_status  (q_status),
    .push      (push),
    .push_data (push_data)
  );

  nfmt_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .q_status  (q_status)
  );

  nfmt_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_status      (q_status),
    .pop_data      (pop_data),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_character (out_character),
    .out_last      (out_last)
  );

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Sends numbers with format codes into number_to_ascii_formatter_top and
// checks each character and its last flag against typed text or a local
// formatter, with random idling on both channels and a long output hold-off.
// ----------------------------------------------------------------------------
module testbench;
  import nfmt_pkg::*;

  // opcodes outside the format set, accepted and dropped by the block
  localparam logic [2:0] OP_RSVD_LO  = 3'd5;
  localparam logic [2:0] OP_RSVD_MID = 3'd6;
  localparam logic [2:0] OP_RSVD_HI  = 3'd7;

  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_LOWER_A = 8'h61;

  localparam int NDIR         = 25;
  localparam int PHASE_ITEMS  = 48;
  localparam int HOLD_CYCLES  = 200;
  localparam int DRAIN_CYCLES = 30;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } char_t;

  // one directed request; typed rows carry their text, right-justified
  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] val;
    logic        typed;
    logic [79:0] txt;
  } row_t;

  localparam row_t DIR_ROWS [NDIR] = '{
    '{FMT_DEC4,    32'd0,          1'b1, 80'("   0")},
    '{FMT_DEC4,    32'd9999,       1'b1, 80'("9999")},
    '{FMT_DEC4,    32'h0000_ffff,  1'b1, 80'("5535")},
    '{FMT_DEC4,    32'd10000,      1'b1, 80'("   0")},
    '{FMT_DEC4,    32'hffff_0007,  1'b0, 80'd0},
    '{FMT_DEC4,    32'd1005,       1'b0, 80'd0},
    '{FMT_DEC4,    32'd40,         1'b0, 80'd0},
    '{FMT_DECU,    32'd0,          1'b1, 80'("0")},
    '{FMT_DECU,    32'hffff_ffff,  1'b1, 80'("4294967295")},
    '{FMT_DECU,    32'd1000000000, 1'b0, 80'd0},
    '{FMT_DECU,    32'd9,          1'b0, 80'd0},
    '{FMT_DECS,    32'd0,          1'b1, 80'("0")},
    '{FMT_DECS,    32'h0000_7fff,  1'b1, 80'("32767")},
    '{FMT_DECS,    32'h0000_8000,  1'b1, 80'("-32768")},
    '{FMT_DECS,    32'h0000_ffff,  1'b1, 80'("-1")},
    '{FMT_DECS,    32'habcd_0005,  1'b0, 80'd0},
    '{FMT_HEX2,    32'd0,          1'b1, 80'("00")},
    '{FMT_HEX2,    32'hffff_ffff,  1'b1, 80'("ff")},
    '{FMT_HEX2,    32'h1234_565a,  1'b0, 80'd0},
    '{FMT_HEX4,    32'd0,          1'b1, 80'("0000")},
    '{FMT_HEX4,    32'hffff_ffff,  1'b1, 80'("ffff")},
    '{FMT_HEX4,    32'h1234_abcd,  1'b0, 80'd0},
    '{OP_RSVD_LO,  32'd0,          1'b1, 80'd0},
    '{OP_RSVD_MID, 32'h5555_aaaa,  1'b1, 80'd0},
    '{OP_RSVD_HI,  32'hffff_ffff,  1'b1, 80'd0}
  };

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  logic [2:0]       in_opcode;
  logic [VAL_W-1:0] in_value;
  logic             out_valid;
  logic             out_stall;
  logic [7:0]       out_character;
  logic             out_last;

  char_t pending_chars [$];
  int    error_count  = 0;
  int    snd_idle_pct = 0;
  int    rcv_idle_pct = 0;
  int    hold_asks    = 0;

  number_to_ascii_formatter_top dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_opcode     (in_opcode),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_character (out_character),
    .out_last      (out_last)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("number_to_ascii_formatter_top verification failed");
    $finish;
  end

  // expected text of one request, appended to pending_chars
  task automatic format_number(input logic [2:0] op, input logic [31:0] val);
    logic [7:0]  txt [$];
    logic [7:0]  digs [$];
    logic [31:0] mag;
    logic [3:0]  nib;
    logic        lead;
    logic        dec;
    int          rem4;
    int          d;
    int          nd;
    char_t       c;
    lead = 1'b1;
    dec  = 1'b0;
    mag  = '0;
    nd   = 0;
    case (op)
      FMT_DEC4: begin
        rem4 = int'(val[15:0]) % 10000;
        // blank leading zeros, but always print the units digit
        for (int p = 1000; p >= 1; p = p / 10) begin
          d = (rem4 / p) % 10;
          if (lead && d == 0 && p != 1) begin
            txt.push_back(CH_SPACE);
          end else begin
            lead = 1'b0;
            txt.push_back(CH_ZERO + 8'(d));
          end
        end
      end
      FMT_DECU: begin
        mag = val;
        dec = 1'b1;
      end
      FMT_DECS: begin
        // two's complement magnitude; 0x8000 comes out as 32768
        if (val[15]) begin
          txt.push_back(CH_MINUS);
          mag = 32'h0001_0000 - {16'h0000, val[15:0]};
        end else begin
          mag = {16'h0000, val[15:0]};
        end
        dec = 1'b1;
      end
      FMT_HEX2: nd = 2;
      FMT_HEX4: nd = 4;
      default: ;
    endcase
    if (dec) begin
      if (mag == 32'd0) begin
        txt.push_back(CH_ZERO);
      end else begin
        while (mag != 32'd0) begin
          digs.push_front(CH_ZERO + 8'(mag % 32'd10));
          mag = mag / 32'd10;
        end
        foreach (digs[i]) txt.push_back(digs[i]);
      end
    end
    for (int k = nd - 1; k >= 0; k--) begin
      nib = val[4*k +: 4];
      txt.push_back(nib < 4'd10 ? CH_ZERO + 8'(nib) : CH_LOWER_A + 8'(nib) - 8'd10);
    end
    foreach (txt[i]) begin
      c.ch   = txt[i];
      c.last = (i == txt.size() - 1);
      pending_chars.push_back(c);
    end
  endtask

  // offer one request; returns at the edge where it is taken
  task automatic offer_number(input logic [2:0] op, input logic [31:0] val);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_opcode <= op;
    in_value  <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // request side
  initial begin : stim
    logic [2:0]  op;
    logic [31:0] val;
    logic [31:0] p;
    int          sent;
    int          n;
    char_t       c;
    in_valid  = 1'b0;
    in_opcode = '0;
    in_value  = '0;
    rst_n     = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    snd_idle_pct = 13;
    rcv_idle_pct = 70;

    // directed table
    foreach (DIR_ROWS[i]) begin
      offer_number(DIR_ROWS[i].op, DIR_ROWS[i].val);
      if (DIR_ROWS[i].typed) begin
        n = 0;
        while (n < 10 && DIR_ROWS[i].txt[8*n +: 8] != 8'h00) n++;
        for (int k = n - 1; k >= 0; k--) begin
          c.ch   = DIR_ROWS[i].txt[8*k +: 8];
          c.last = (k == 0);
          pending_chars.push_back(c);
        end
      end else begin
        format_number(DIR_ROWS[i].op, DIR_ROWS[i].val);
      end
    end

    // random phases, each started from an empty pipe
    for (int ph = 0; ph < 3; ph++) begin
      in_valid <= 1'b0;
      while (pending_chars.size() != 0) @(posedge clk);
      case (ph)
        0: begin
          snd_idle_pct = 13;
          rcv_idle_pct = 70;
        end
        1: begin
          snd_idle_pct = 70;
          rcv_idle_pct = 13;
        end
        default: begin
          snd_idle_pct = 0;
          rcv_idle_pct = 0;
          // long output hold-off while requests keep coming
          hold_asks <= hold_asks + 1;
        end
      endcase
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if ($urandom_range(99) < 8) op = 3'($urandom_range(OP_RSVD_HI, OP_RSVD_LO));
        else op = 3'($urandom_range(FMT_HEX4));
        case ($urandom_range(5))
          0: val = $urandom();
          1: val = $urandom() >> $urandom_range(31);
          2: val = $urandom_range(20);
          3: begin
            // around a power of ten
            p = 32'd1;
            repeat ($urandom_range(9)) p = p * 32'd10;
            val = p + 32'($urandom_range(2)) - 32'd1;
          end
          4: val = $urandom() | 32'h0000_8000;
          default: val = 32'hffff_ffff - 32'($urandom_range(20));
        endcase
        offer_number(op, val);
        format_number(op, val);
        if (op <= FMT_HEX4) sent++;
      end
    end

    // drain and finish
    in_valid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("number_to_ascii_formatter_top verification clean");
    end else begin
      $display("number_to_ascii_formatter_top verification failed");
    end
    $finish;
  end

  // character side: check accepted characters, drive stall
  initial begin : sink
    int    hold_left;
    int    holds_seen;
    char_t c;
    hold_left  = 0;
    holds_seen = 0;
    out_stall  = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        if (pending_chars.size() == 0) begin
          $error("unexpected character: actual %h, last %b", out_character, out_last);
          error_count++;
        end else begin
          c = pending_chars.pop_front();
          if (out_character !== c.ch) begin
            $error("character: expected %h, actual %h", c.ch, out_character);
            error_count++;
          end
          if (out_last !== c.last) begin
            $error("last: expected %b, actual %b", c.last, out_last);
            error_count++;
          end
        end
      end
      if (hold_asks != holds_seen) begin
        holds_seen = hold_asks;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < rcv_idle_pct);
      end
    end
  end

endmodule
